// File: hw/rtl/epr_pkg.sv
// Shared types, constants and helper functions for the effect-region waveform selector.
package epr_pkg;

  localparam int COORD_BITS = 12;
  localparam int WAVE_BITS = 4;
  localparam int THRESH_BITS = 16;
  localparam int FLAG_BITS = 4;
  localparam int RES_BITS = 13;
  localparam int PCT_BITS = 7;
  localparam int AREA_BITS = 2 * (COORD_BITS + 1);
  localparam int DEN_BITS = 2 * RES_BITS;
  localparam int CMP_BITS = DEN_BITS + PCT_BITS;
  localparam int PERCENT_SCALE = 100;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_UPDATE = 2'd0;
  localparam cmd_t CMD_SET = 2'd1;
  localparam cmd_t CMD_RESET = 2'd2;

  localparam int FLAG_ACTIVE = 0;
  localparam int FLAG_ONESHOT = 1;
  localparam int FLAG_CLEAR = 2;
  localparam int FLAG_REGION = 3;

  localparam logic [WAVE_BITS-1:0] WV_GC = 4'd0;
  localparam logic [WAVE_BITS-1:0] WV_AUTO = 4'd7;

  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GC_PERCENT = 2'd2;

  localparam logic [RES_BITS-1:0] SCREEN_WIDTH_RESET = 13'd800;
  localparam logic [RES_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd600;
  localparam logic [PCT_BITS-1:0] GC_PERCENT_RESET = 7'd0;

  typedef struct packed {
    cmd_t cmd;
    logic [COORD_BITS-1:0] rect_x0;
    logic [COORD_BITS-1:0] rect_y0;
    logic [COORD_BITS-1:0] rect_x1;
    logic [COORD_BITS-1:0] rect_y1;
    logic [WAVE_BITS-1:0] waveform;
    logic [THRESH_BITS-1:0] threshold;
    logic [FLAG_BITS-1:0] region_flags;
    logic [2:0] region_index;
    logic [7:0] region_mask;
  } req_t;

  typedef struct packed {
    logic matched;
    logic [COORD_BITS-1:0] out_x0;
    logic [COORD_BITS-1:0] out_y0;
    logic [COORD_BITS-1:0] out_x1;
    logic [COORD_BITS-1:0] out_y1;
    logic [WAVE_BITS-1:0] out_waveform;
    logic [THRESH_BITS-1:0] out_threshold;
    logic [7:0] active_regions;
  } rsp_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic [RES_BITS-1:0] screen_width;
    logic [RES_BITS-1:0] screen_height;
    logic [PCT_BITS-1:0] gc_percent;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic table_wr;
    logic scan;
    logic mul1;
    logic mul2;
    logic promote;
    logic finish;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic take;
    logic need_pct;
    logic last;
    logic out_free;
  } stat_t;

  // Last pixel index of a screen dimension, saturated to the coordinate range.
  function automatic logic [COORD_BITS-1:0] last_coord(input logic [RES_BITS-1:0] res);
    logic [RES_BITS-1:0] m;
    m = res - 13'd1;
    if (res == '0) begin
      return '0;
    end else if (m > RES_BITS'((1 << COORD_BITS) - 1)) begin
      return '1;
    end else begin
      return m[COORD_BITS-1:0];
    end
  endfunction

  function automatic logic rect_covers(input rect_t a, input rect_t b);
    return b.x0 >= a.x0 && b.x0 <= a.x1 && b.x1 >= a.x0 && b.x1 <= a.x1 &&
           b.y0 >= a.y0 && b.y0 <= a.y1 && b.y1 >= a.y0 && b.y1 <= a.y1;
  endfunction

endpackage

// File: hw/rtl/epr_ctrl.sv
// Control state machine that sequences table writes, region scan and area check.
module epr_ctrl import epr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_PROMO = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        ctl.load = req_valid;
        if (req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.cmd == CMD_UPDATE) begin
          state_next = S_SCAN;
        end else begin
          ctl.table_wr = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.take) state_next = S_FINISH;
        else if (stat.need_pct) state_next = S_MUL1;
        else if (stat.last) state_next = S_FINISH;
      end
      S_MUL1: begin
        ctl.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        ctl.mul2 = 1'b1;
        state_next = S_PROMO;
      end
      S_PROMO: begin
        ctl.promote = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.finish = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/epr_datapath.sv
// Region table, request registers, area multipliers and the output register.
module epr_datapath import epr_pkg::*; #(
  parameter int REGION_COUNT = 8
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cfg_t  cfg,
  input  ctl_t  ctl,
  output stat_t stat,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp
);

  localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int MW = (REGION_COUNT > 8) ? REGION_COUNT : 8;

  rect_t rect_tab [REGION_COUNT];
  logic [WAVE_BITS-1:0] wave_tab [REGION_COUNT];
  logic [THRESH_BITS-1:0] thresh_tab [REGION_COUNT];
  logic [FLAG_BITS-1:0] flags [REGION_COUNT];

  cmd_t cmd;
  rect_t p;
  logic [WAVE_BITS-1:0] wv;
  logic [THRESH_BITS-1:0] th;
  logic [FLAG_BITS-1:0] set_flags;
  logic [2:0] set_index;
  logic [MW-1:0] mask;
  logic matched;
  logic [IDX_W-1:0] idx;

  logic signed [AREA_BITS-1:0] area;
  logic [DEN_BITS-1:0] den;
  logic area_neg;
  logic [CMP_BITS-1:0] num;
  logic [CMP_BITS-1:0] lim;

  rect_t e_rect;
  logic [FLAG_BITS-1:0] e_fl;
  logic part, hit_os, hit_act, hit_clr;
  logic signed [COORD_BITS:0] w, h;
  logic pct_en;
  rect_t full;
  logic [MW-1:0] act_ext;
  logic set_ok;

  assign e_rect = rect_tab[idx];
  assign e_fl = flags[idx];
  assign part = (e_fl[FLAG_ACTIVE] | e_fl[FLAG_ONESHOT] | e_fl[FLAG_CLEAR]) &
                rect_covers(e_rect, p);
  assign hit_os = part & e_fl[FLAG_ONESHOT];
  assign hit_act = part & ~e_fl[FLAG_ONESHOT] & e_fl[FLAG_ACTIVE];
  assign hit_clr = part & ~e_fl[FLAG_ONESHOT] & ~e_fl[FLAG_ACTIVE] & e_fl[FLAG_CLEAR] &
                   (e_rect == p);

  assign stat.cmd = cmd;
  assign stat.need_pct = hit_act & (wave_tab[idx] == WV_AUTO);
  assign stat.take = hit_os | (hit_act & (wave_tab[idx] != WV_AUTO)) | hit_clr;
  assign stat.last = idx == IDX_W'(REGION_COUNT - 1);
  assign stat.out_free = ~rsp_valid | ~rsp_stall;

  assign w = signed'({1'b0, p.x1}) - signed'({1'b0, p.x0});
  assign h = signed'({1'b0, p.y1}) - signed'({1'b0, p.y0});
  assign pct_en = cfg.gc_percent != '0 && cfg.screen_width >= 13'd2 &&
                  cfg.screen_height >= 13'd2;
  assign full.x0 = '0;
  assign full.y0 = '0;
  assign full.x1 = last_coord(cfg.screen_width);
  assign full.y1 = last_coord(cfg.screen_height);
  assign set_ok = int'(set_index) < REGION_COUNT;

  for (genvar gi = 0; gi < MW; gi++) begin : g_act
    if (gi < REGION_COUNT) begin : g_on
      assign act_ext[gi] = |flags[gi];
    end else begin : g_off
      assign act_ext[gi] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        flags[i] <= '0;
      end
    end else if (ctl.table_wr) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        if (cmd == CMD_SET && set_ok && int'(set_index) == i) begin
          flags[i] <= set_flags;
        end else if (cmd == CMD_RESET && mask[i]) begin
          flags[i] <= '0;
        end
      end
    end else if (ctl.scan && (hit_os || hit_clr)) begin
      flags[idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.table_wr && cmd == CMD_SET && set_ok && set_flags != '0) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        if (int'(set_index) == i) begin
          rect_tab[i] <= p;
          wave_tab[i] <= wv;
          thresh_tab[i] <= th;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= req.cmd;
      p <= '{x0: req.rect_x0, y0: req.rect_y0, x1: req.rect_x1, y1: req.rect_y1};
      wv <= req.waveform;
      th <= req.threshold;
      set_flags <= req.region_flags;
      set_index <= req.region_index;
      mask <= MW'(req.region_mask);
      matched <= 1'b0;
      idx <= '0;
    end else if (ctl.scan) begin
      if (hit_os) begin
        wv <= wave_tab[idx];
        th <= thresh_tab[idx];
        if (e_fl[FLAG_REGION]) p <= e_rect;
        matched <= 1'b1;
      end else if (hit_act) begin
        wv <= wave_tab[idx];
        th <= thresh_tab[idx];
        if (e_fl[FLAG_REGION] && wave_tab[idx] != WV_AUTO) p <= e_rect;
        matched <= 1'b1;
      end else if (hit_clr) begin
        wv <= WV_GC;
        th <= thresh_tab[idx];
        p <= full;
        matched <= 1'b1;
      end else if (!stat.last) begin
        idx <= idx + 1'b1;
      end
    end else if (ctl.promote) begin
      if (pct_en && !area_neg && num >= lim) begin
        wv <= WV_GC;
        th <= '0;
        p <= full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      area <= AREA_BITS'(w) * AREA_BITS'(h);
      den <= DEN_BITS'(cfg.screen_width - 13'd1) * DEN_BITS'(cfg.screen_height - 13'd1);
    end
    if (ctl.mul2) begin
      area_neg <= area[AREA_BITS-1];
      num <= CMP_BITS'(area[AREA_BITS-2:0]) * CMP_BITS'(PERCENT_SCALE);
      lim <= CMP_BITS'(den) * CMP_BITS'(cfg.gc_percent);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      rsp.active_regions <= act_ext[7:0];
      if (cmd == CMD_UPDATE) begin
        rsp.matched <= matched;
        rsp.out_x0 <= p.x0;
        rsp.out_y0 <= p.y0;
        rsp.out_x1 <= p.x1;
        rsp.out_y1 <= p.y1;
        rsp.out_waveform <= wv;
        rsp.out_threshold <= th;
      end else begin
        rsp.matched <= 1'b0;
        rsp.out_x0 <= '0;
        rsp.out_y0 <= '0;
        rsp.out_x1 <= '0;
        rsp.out_y1 <= '0;
        rsp.out_waveform <= '0;
        rsp.out_threshold <= '0;
      end
    end
  end

endmodule

// File: hw/rtl/epaper_region_waveform_select.sv
// Top level of the effect-region waveform selector with its configuration registers.
//
// Each item is a set, reset or update command and produces one result item;
// other codes also give one and leave the table alone. Set and reset write
// the table in the dispatch state. An update scans the region table one
// entry per cycle in index order and stops at the first matching entry (up
// to REGION_COUNT entries); an active AUTO match adds the two-step area
// multiply and compare. One item is in work at a time; the output register
// lets the next item be accepted while a result waits.
module epaper_region_waveform_select import epr_pkg::*; #(
  parameter int REGION_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  ctl_t ctl;
  stat_t stat;
  logic [1:0] reg_index;

  assign pready = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width <= SCREEN_WIDTH_RESET;
      cfg.screen_height <= SCREEN_HEIGHT_RESET;
      cfg.gc_percent <= GC_PERCENT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_SCREEN_WIDTH: cfg.screen_width <= pwdata[RES_BITS-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[RES_BITS-1:0];
        REG_GC_PERCENT: cfg.gc_percent <= pwdata[PCT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SCREEN_WIDTH: prdata = 32'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = 32'(cfg.screen_height);
      REG_GC_PERCENT: prdata = 32'(cfg.gc_percent);
      default: prdata = '0;
    endcase
  end

  epr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  epr_datapath #(
    .REGION_COUNT (REGION_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: verif/epaper_region_waveform_select_test.sv
// Self-checking testbench for the effect-region waveform selector.
module epaper_region_waveform_select_test;
  import epr_pkg::*;

  localparam int REGIONS = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 262;
  localparam int PHASES = 7;

  localparam cmd_t CMD_NONE = 2'd3;
  localparam logic [3:0] F_ACTIVE = 4'd1 << FLAG_ACTIVE;
  localparam logic [3:0] F_ONESHOT = 4'd1 << FLAG_ONESHOT;
  localparam logic [3:0] F_CLEAR = 4'd1 << FLAG_CLEAR;
  localparam logic [3:0] F_REGION = 4'd1 << FLAG_REGION;
  localparam logic [3:0] WV_DU = 4'd2;
  localparam logic [3:0] WV_A2 = 4'd3;
  localparam logic [3:0] WV_X1 = 4'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  epaper_region_waveform_select u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  // Expected state of the region table and the registers.
  rect_t tbl_rect [REGIONS] = '{default: '0};
  logic [3:0] tbl_wave [REGIONS] = '{default: '0};
  logic [15:0] tbl_thresh [REGIONS] = '{default: '0};
  logic [3:0] tbl_flags [REGIONS] = '{default: '0};
  logic [7:0] tbl_live = '0;
  logic [12:0] cfg_width = 13'd800;
  logic [12:0] cfg_height = 13'd600;
  logic [6:0] cfg_pct = 7'd0;

  req_t req_backlog [$];
  rsp_t expected_rsp [$];
  rect_t gen_rect [REGIONS] = '{default: '0};

  int fail_count = 0;
  int sent_count = 0;
  int match_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int send_quiet = 0;
  int recv_quiet = 0;
  rsp_t want;

  function automatic logic [11:0] last_pixel(logic [12:0] res);
    if (res == '0) begin
      return '0;
    end
    if (res - 13'd1 > 13'd4095) begin
      return 12'hFFF;
    end
    return 12'(res - 13'd1);
  endfunction

  function automatic rect_t full_screen_rect();
    rect_t q;
    q.x0 = '0;
    q.y0 = '0;
    q.x1 = last_pixel(cfg_width);
    q.y1 = last_pixel(cfg_height);
    return q;
  endfunction

  function automatic rsp_t select_waveform(req_t r);
    rsp_t o;
    rect_t p;
    logic [3:0] wv;
    logic [15:0] th;
    logic hit;
    longint w, h, num, den;
    logic promote;
    o = '0;
    p = '{r.rect_x0, r.rect_y0, r.rect_x1, r.rect_y1};
    wv = r.waveform;
    th = r.threshold;
    hit = 1'b0;
    case (r.cmd)
      CMD_UPDATE: begin
        for (int i = 0; i < REGIONS; i++) begin
          if (!tbl_live[i]) continue;
          if (!(tbl_flags[i][FLAG_ONESHOT] || tbl_flags[i][FLAG_ACTIVE] ||
                tbl_flags[i][FLAG_CLEAR])) continue;
          if (!(p.x0 >= tbl_rect[i].x0 && p.x0 <= tbl_rect[i].x1 &&
                p.x1 >= tbl_rect[i].x0 && p.x1 <= tbl_rect[i].x1 &&
                p.y0 >= tbl_rect[i].y0 && p.y0 <= tbl_rect[i].y1 &&
                p.y1 >= tbl_rect[i].y0 && p.y1 <= tbl_rect[i].y1)) continue;
          if (tbl_flags[i][FLAG_ONESHOT]) begin
            wv = tbl_wave[i];
            th = tbl_thresh[i];
            if (tbl_flags[i][FLAG_REGION]) begin
              p = tbl_rect[i];
            end
            tbl_flags[i] = '0;
            tbl_live[i] = 1'b0;
            hit = 1'b1;
          end else if (tbl_flags[i][FLAG_ACTIVE]) begin
            wv = tbl_wave[i];
            th = tbl_thresh[i];
            hit = 1'b1;
            if (wv == WV_AUTO) begin
              w = longint'(p.x1) - longint'(p.x0);
              h = longint'(p.y1) - longint'(p.y0);
              num = w * h * 100;
              promote = 1'b0;
              if (cfg_pct != 0 && num >= 0 && cfg_width >= 2 && cfg_height >= 2) begin
                den = (longint'(cfg_width) - 1) * (longint'(cfg_height) - 1);
                promote = (num / den) >= longint'(cfg_pct);
              end
              if (promote) begin
                p = full_screen_rect();
                wv = WV_GC;
                th = '0;
              end
            end else if (tbl_flags[i][FLAG_REGION]) begin
              p = tbl_rect[i];
            end
          end else if (p == tbl_rect[i]) begin
            th = tbl_thresh[i];
            p = full_screen_rect();
            wv = WV_GC;
            tbl_flags[i] = '0;
            tbl_live[i] = 1'b0;
            hit = 1'b1;
          end
          if (hit) break;
        end
      end
      CMD_SET: begin
        if (r.region_flags != '0) begin
          tbl_rect[r.region_index] = p;
          tbl_wave[r.region_index] = wv;
          tbl_thresh[r.region_index] = th;
        end
        tbl_flags[r.region_index] = r.region_flags;
        tbl_live[r.region_index] = r.region_flags != '0;
      end
      CMD_RESET: begin
        for (int i = 0; i < REGIONS; i++) begin
          if (r.region_mask[i]) begin
            tbl_rect[i] = '0;
            tbl_wave[i] = '0;
            tbl_thresh[i] = '0;
            tbl_flags[i] = '0;
            tbl_live[i] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    if (r.cmd != CMD_UPDATE) begin
      p = '0;
      wv = '0;
      th = '0;
    end
    o.matched = hit;
    o.out_x0 = p.x0;
    o.out_y0 = p.y0;
    o.out_x1 = p.x1;
    o.out_y1 = p.y1;
    o.out_waveform = wv;
    o.out_threshold = th;
    o.active_regions = tbl_live;
    return o;
  endfunction

  // Mostly short pauses, a few long ones, and now and then a run with none.
  function automatic int pause_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t make_req(cmd_t c, int x0, int y0, int x1, int y1,
                                    logic [3:0] wv, int th, logic [3:0] fl,
                                    int idx, int msk);
    req_t r;
    r.cmd = c;
    r.rect_x0 = 12'(x0);
    r.rect_y0 = 12'(y0);
    r.rect_x1 = 12'(x1);
    r.rect_y1 = 12'(y1);
    r.waveform = wv;
    r.threshold = 16'(th);
    r.region_flags = fl;
    r.region_index = 3'(idx);
    r.region_mask = 8'(msk);
    return r;
  endfunction

  function automatic rect_t rand_rect();
    rect_t q;
    int span, x0, y0, x1, y1, t;
    if ($urandom_range(0, 9) == 0) begin
      return '{12'd0, 12'd0, 12'hFFF, 12'hFFF};
    end
    case ($urandom_range(0, 3))
      0: span = 15;
      1: span = 255;
      default: span = 4095;
    endcase
    x0 = $urandom_range(0, 4095 - span / 2);
    y0 = $urandom_range(0, 4095 - span / 2);
    x1 = x0 + $urandom_range(0, span);
    y1 = y0 + $urandom_range(0, span);
    if (x1 > 4095) x1 = 4095;
    if (y1 > 4095) y1 = 4095;
    if ($urandom_range(0, 9) == 0) begin
      t = x0;
      x0 = x1;
      x1 = t;
    end
    if ($urandom_range(0, 9) == 0) begin
      t = y0;
      y0 = y1;
      y1 = t;
    end
    q = '{12'(x0), 12'(y0), 12'(x1), 12'(y1)};
    return q;
  endfunction

  function automatic req_t random_item();
    req_t r;
    rect_t a, b;
    int sel, s;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r = req_t'(raw[$bits(req_t)-1:0]);
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      r.cmd = CMD_SET;
      r.region_flags = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      b = rand_rect();
      r.waveform = ($urandom_range(0, 2) == 0) ? WV_AUTO : 4'($urandom_range(0, 15));
    end else if (sel < 18) begin
      r.cmd = CMD_RESET;
      if ($urandom_range(0, 1) == 0) begin
        r.region_mask = 8'(1 << $urandom_range(0, 7));
      end
      b = rand_rect();
    end else if (sel < 20) begin
      r.cmd = CMD_NONE;
      b = rand_rect();
    end else begin
      r.cmd = CMD_UPDATE;
      a = gen_rect[$urandom_range(0, REGIONS - 1)];
      s = $urandom_range(0, 9);
      if (s < 6) begin
        b.x0 = 12'($urandom_range(a.x0, a.x1));
        b.x1 = 12'($urandom_range(b.x0, a.x1));
        b.y0 = 12'($urandom_range(a.y0, a.y1));
        b.y1 = 12'($urandom_range(b.y0, a.y1));
      end else if (s < 8) begin
        b = a;
      end else begin
        b = rand_rect();
      end
    end
    r.rect_x0 = b.x0;
    r.rect_y0 = b.y0;
    r.rect_x1 = b.x1;
    r.rect_y1 = b.y1;
    return r;
  endfunction

  task automatic push_item(req_t r);
    if (r.cmd == CMD_SET && r.region_flags != '0) begin
      gen_rect[r.region_index] = '{r.rect_x0, r.rect_y0, r.rect_x1, r.rect_y1};
    end
    req_backlog.push_back(r);
  endtask

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH: cfg_width = val[12:0];
      REG_SCREEN_HEIGHT: cfg_height = val[12:0];
      REG_GC_PERCENT: cfg_pct = val[6:0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    while (!(req_backlog.size() == 0 && !req_valid && expected_rsp.size() == 0)) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(string name, longint unsigned exp_val,
                               longint unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsp.push_back(select_waveform(req));
        sent_count++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
          gap_left = pause_len(send_quiet);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: result item with nothing expected: %h", $time, rsp);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          compare_field("matched", want.matched, rsp.matched);
          compare_field("out_x0", want.out_x0, rsp.out_x0);
          compare_field("out_y0", want.out_y0, rsp.out_y0);
          compare_field("out_x1", want.out_x1, rsp.out_x1);
          compare_field("out_y1", want.out_y1, rsp.out_y1);
          compare_field("out_waveform", want.out_waveform, rsp.out_waveform);
          compare_field("out_threshold", want.out_threshold, rsp.out_threshold);
          compare_field("active_regions", want.active_regions, rsp.active_regions);
          if (rsp.matched) match_count++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        stall_left = pause_len(recv_quiet);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_rsp.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned phase_w [PHASES] = '{800, 2, 4096, 1, 8191, 320, 1024};
    int unsigned phase_h [PHASES] = '{600, 2, 4096, 600, 0, 240, 768};
    int unsigned phase_pct [PHASES] = '{50, 1, 100, 10, 127, 25, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) wait_drained();
      cfg_write(REG_SCREEN_WIDTH, phase_w[ph]);
      cfg_write(REG_SCREEN_HEIGHT, phase_h[ph]);
      cfg_write(REG_GC_PERCENT, phase_pct[ph]);
      if (ph == 0) begin
        push_item(make_req(CMD_UPDATE, 0, 0, 4095, 4095, 4'hF, 'hFFFF, 4'hF, 7, 'hFF));
        push_item(make_req(CMD_SET, 0, 0, 4095, 4095, WV_GC, 0, F_REGION, 0, 0));
        push_item(make_req(CMD_UPDATE, 5, 5, 6, 6, WV_DU, 1, 0, 0, 0));
        push_item(make_req(CMD_SET, 100, 100, 500, 400, WV_A2, 1234,
                           F_ONESHOT | F_REGION, 1, 0));
        push_item(make_req(CMD_UPDATE, 150, 150, 200, 200, WV_DU, 5, 0, 0, 0));
        push_item(make_req(CMD_UPDATE, 150, 150, 200, 200, WV_DU, 5, 0, 0, 0));
        push_item(make_req(CMD_SET, 0, 0, 4095, 4095, WV_AUTO, 'hFFFF, F_ACTIVE, 2, 0));
        push_item(make_req(CMD_UPDATE, 0, 0, 799, 599, WV_DU, 3, 0, 0, 0));
        push_item(make_req(CMD_UPDATE, 10, 10, 20, 20, WV_DU, 3, 0, 0, 0));
        push_item(make_req(CMD_UPDATE, 20, 10, 10, 4095, WV_DU, 3, 0, 0, 0));
        push_item(make_req(CMD_RESET, 0, 0, 0, 0, WV_GC, 0, 0, 0, 'h04));
        push_item(make_req(CMD_SET, 1000, 1000, 2000, 2000, WV_X1, 42,
                           F_ACTIVE | F_REGION, 3, 0));
        push_item(make_req(CMD_UPDATE, 1500, 1500, 1600, 1600, WV_DU, 8, 0, 0, 0));
        push_item(make_req(CMD_SET, 10, 20, 30, 40, WV_DU, 777, F_CLEAR, 7, 0));
        push_item(make_req(CMD_UPDATE, 10, 20, 30, 40, WV_A2, 9, 0, 0, 0));
        push_item(make_req(CMD_SET, 10, 20, 30, 40, WV_DU, 555, F_CLEAR, 6, 0));
        push_item(make_req(CMD_UPDATE, 11, 20, 30, 40, WV_A2, 9, 0, 0, 0));
        push_item(make_req(CMD_SET, 0, 0, 0, 0, WV_GC, 0, 0, 6, 0));
        push_item(make_req(CMD_UPDATE, 10, 20, 30, 40, WV_A2, 9, 0, 0, 0));
        push_item(make_req(CMD_SET, 3000, 3000, 4095, 4095, WV_X1, 'hFFFF, 4'hF, 4, 0));
        push_item(make_req(CMD_UPDATE, 3500, 3500, 4000, 4000, WV_DU, 1, 0, 0, 0));
        push_item(make_req(CMD_NONE, 1, 2, 3, 4, 4'd9, 99, 4'hF, 5, 'hAA));
        push_item(make_req(CMD_RESET, 0, 0, 0, 0, WV_GC, 0, 0, 0, 'hFF));
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        push_item(random_item());
      end
    end
    wait_drained();
    $display("Sent %0d items over %0d register settings; %0d updates were rewritten.",
             sent_count, PHASES, match_count);
    $display("Settings ranged over tiny, saturating and zero-sized screens and all thresholds.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
